// File: sv/tamacd_pkg.sv
// Shared constants and types for the three-axis moving average with change detection.
package tamacd_pkg;

  localparam int unsigned WINDOW    = 10;
  localparam int unsigned AXES      = 3;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned THR_W     = 15;
  localparam int unsigned THR_RESET = 209;

  localparam int unsigned WIN_LOG = $clog2(WINDOW);
  localparam int unsigned SLOT_W  = (WIN_LOG < 1) ? 1 : WIN_LOG;
  localparam int unsigned SUM_W   = DATA_W + WIN_LOG;
  localparam int unsigned DIFF_W  = SUM_W + 1;
  localparam int unsigned LIM_W   = THR_W + WIN_LOG;

  // Division by WINDOW is a multiplication by a rounded-up reciprocal.
  localparam int unsigned DIV_N  = SUM_W;
  localparam int unsigned DIV_S  = DIV_N + WIN_LOG;
  localparam int unsigned RCP_W  = DIV_N + 1;
  localparam int unsigned PROD_W = DIV_N + RCP_W;
  localparam longint unsigned DIV_RCP =
      ((longint'(1) << DIV_S) + longint'(WINDOW) - 1) / longint'(WINDOW);

  typedef logic signed [DATA_W-1:0] smp_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [LIM_W-1:0]         lim_t;
  typedef logic [SLOT_W-1:0]        slot_t;

  localparam sum_t WINDOW_S  = sum_t'(WINDOW);
  localparam lim_t LIM_RESET = lim_t'(THR_RESET * WINDOW);

endpackage

// File: sv/three_axis_moving_average_change_detect_top.sv
// Top level of the three-axis moving average filter with change detection.
// Each accepted request carries one signed three-axis sample. The block keeps a ring of the
// last WINDOW samples per axis and returns the three window averages, truncated toward zero,
// with a flag that is set when any axis sum moved by more than WINDOW times change_threshold
// since the previous sample. The first request after reset only primes the previous sums and
// returns no result. The block takes a request in every cycle unless back-pressure from the
// output holds it; after the input register, each request passes through the running-sum
// update, the reciprocal multiply for the division, and the output register. Threshold
// writes are always accepted.
module three_axis_moving_average_change_detect_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            accel_x_i,
  input  logic signed [15:0]            accel_y_i,
  input  logic signed [15:0]            accel_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            avg_x_o,
  output logic signed [15:0]            avg_y_o,
  output logic signed [15:0]            avg_z_o,
  output logic                          changed_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tamacd_pkg::THR_W-1:0]  change_threshold_i
);

  localparam int unsigned AXES   = tamacd_pkg::AXES;
  localparam int unsigned WINDOW = tamacd_pkg::WINDOW;
  localparam int unsigned DATA_W = tamacd_pkg::DATA_W;

  logic                  out_adv, s3_adv, s2_adv, s1_adv;
  tamacd_pkg::lim_t      lim_q;

  logic                  s1_v_q;
  tamacd_pkg::smp_t      s1_smp_q [AXES];
  tamacd_pkg::smp_t      in_smp   [AXES];

  tamacd_pkg::smp_t      ring_q   [AXES][WINDOW];
  tamacd_pkg::sum_t      sum_q    [AXES];
  tamacd_pkg::sum_t      prior_q  [AXES];
  tamacd_pkg::slot_t     slot_q;
  logic                  primed_q;

  tamacd_pkg::sum_t      new_sum  [AXES];
  tamacd_pkg::sum_t      prime_sum[AXES];
  tamacd_pkg::diff_t     new_diff [AXES];

  logic                  s2_v_q;
  tamacd_pkg::sum_t      s2_sum_q [AXES];
  tamacd_pkg::diff_t     s2_diff_q[AXES];

  logic [tamacd_pkg::SUM_W-1:0]  sum_mag  [AXES];
  logic [tamacd_pkg::PROD_W-1:0] prod     [AXES];
  logic [DATA_W-1:0]             quo      [AXES];
  logic [tamacd_pkg::DIFF_W-1:0] diff_mag [AXES];
  logic                          chg;

  logic                  s3_v_q;
  logic                  s3_neg_q [AXES];
  logic [DATA_W-1:0]     s3_quo_q [AXES];
  logic                  s3_chg_q;

  logic                  out_v_q;
  tamacd_pkg::smp_t      out_avg_q[AXES];
  logic                  out_chg_q;

  assign out_adv    = !out_v_q || out_ready_i;
  assign s3_adv     = !s3_v_q || out_adv;
  assign s2_adv     = !s2_v_q || s3_adv;
  assign s1_adv     = !s1_v_q || s2_adv;
  assign in_ready_o = s1_adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= tamacd_pkg::LIM_RESET;
    end else if (cfg_valid_i) begin
      lim_q <= tamacd_pkg::lim_t'(change_threshold_i * WINDOW);
    end
  end

  always_comb begin
    in_smp[0] = accel_x_i;
    in_smp[1] = accel_y_i;
    in_smp[2] = accel_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      for (int a = 0; a < AXES; a++) begin
        s1_smp_q[a] <= in_smp[a];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      new_sum[a]   = sum_q[a] + tamacd_pkg::sum_t'(s1_smp_q[a])
                     - tamacd_pkg::sum_t'(ring_q[a][slot_q]);
      prime_sum[a] = tamacd_pkg::sum_t'(s1_smp_q[a]) * tamacd_pkg::WINDOW_S;
      new_diff[a]  = tamacd_pkg::diff_t'(new_sum[a]) - tamacd_pkg::diff_t'(prior_q[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q   <= 1'b0;
      slot_q   <= '0;
      primed_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_q[a]   <= '0;
        prior_q[a] <= '0;
        for (int w = 0; w < WINDOW; w++) begin
          ring_q[a][w] <= '0;
        end
      end
    end else if (s2_adv) begin
      s2_v_q <= s1_v_q && primed_q;
      if (s1_v_q) begin
        if (!primed_q) begin
          primed_q <= 1'b1;
          for (int a = 0; a < AXES; a++) begin
            prior_q[a] <= prime_sum[a];
          end
        end else begin
          for (int a = 0; a < AXES; a++) begin
            sum_q[a]          <= new_sum[a];
            prior_q[a]        <= new_sum[a];
            ring_q[a][slot_q] <= s1_smp_q[a];
          end
          if (slot_q == tamacd_pkg::slot_t'(WINDOW - 1)) begin
            slot_q <= '0;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_v_q && primed_q) begin
      for (int a = 0; a < AXES; a++) begin
        s2_sum_q[a]  <= new_sum[a];
        s2_diff_q[a] <= new_diff[a];
      end
    end
  end

  always_comb begin
    chg = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      sum_mag[a]  = s2_sum_q[a][tamacd_pkg::SUM_W-1] ? -s2_sum_q[a] : s2_sum_q[a];
      prod[a]     = tamacd_pkg::PROD_W'(sum_mag[a])
                    * tamacd_pkg::PROD_W'(tamacd_pkg::DIV_RCP);
      quo[a]      = prod[a][tamacd_pkg::DIV_S +: DATA_W];
      diff_mag[a] = s2_diff_q[a][tamacd_pkg::DIFF_W-1] ? -s2_diff_q[a] : s2_diff_q[a];
      if (diff_mag[a] > tamacd_pkg::DIFF_W'(lim_q)) begin
        chg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_adv) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv && s2_v_q) begin
      s3_chg_q <= chg;
      for (int a = 0; a < AXES; a++) begin
        s3_neg_q[a] <= s2_sum_q[a][tamacd_pkg::SUM_W-1];
        s3_quo_q[a] <= quo[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s3_v_q) begin
      out_chg_q <= s3_chg_q;
      for (int a = 0; a < AXES; a++) begin
        out_avg_q[a] <= s3_neg_q[a] ? -s3_quo_q[a] : s3_quo_q[a];
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign avg_x_o     = out_avg_q[0];
  assign avg_y_o     = out_avg_q[1];
  assign avg_z_o     = out_avg_q[2];
  assign changed_o   = out_chg_q;

endmodule

// File: tb/sv/three_axis_moving_average_change_detect_checker.sv
// Checker that predicts and compares the window averages and change flags of the block.
module three_axis_moving_average_change_detect_checker
  import tamacd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  smp_t             accel_x_i,
  input  smp_t             accel_y_i,
  input  smp_t             accel_z_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  smp_t             avg_x_i,
  input  smp_t             avg_y_i,
  input  smp_t             avg_z_i,
  input  logic             changed_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [THR_W-1:0] change_threshold_i,
  output int               mismatch_count_o,
  output int               pending_averages_o
);

  localparam longint WIN = WINDOW;

  typedef struct packed {
    smp_t x;
    smp_t y;
    smp_t z;
    logic changed;
  } average_t;

  average_t         expected_averages[$];
  average_t         want;
  smp_t             window_ring[AXES][WINDOW];
  longint           window_sum[AXES];
  longint           last_sum[AXES];
  int unsigned      next_slot;
  bit               primed;
  logic [THR_W-1:0] threshold;
  int               mismatches;
  int               pending;

  assign mismatch_count_o   = mismatches;
  assign pending_averages_o = pending;

  function automatic void filter_sample(input smp_t sx, input smp_t sy, input smp_t sz);
    smp_t     smp[AXES];
    longint   limit;
    longint   delta;
    average_t avg;
    smp[0] = sx;
    smp[1] = sy;
    smp[2] = sz;
    if (!primed) begin
      for (int a = 0; a < AXES; a++) begin
        last_sum[a] = longint'(smp[a]) * WIN;
      end
      primed = 1'b1;
      return;
    end
    limit = WIN * longint'(threshold);
    avg.changed = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      window_sum[a] = window_sum[a] + longint'(smp[a]) - longint'(window_ring[a][next_slot]);
      window_ring[a][next_slot] = smp[a];
      delta = window_sum[a] - last_sum[a];
      if (delta < 0) begin
        delta = -delta;
      end
      if (delta > limit) begin
        avg.changed = 1'b1;
      end
      last_sum[a] = window_sum[a];
    end
    avg.x = smp_t'(window_sum[0] / WIN);
    avg.y = smp_t'(window_sum[1] / WIN);
    avg.z = smp_t'(window_sum[2] / WIN);
    next_slot = (next_slot + 1) % WINDOW;
    expected_averages.push_back(avg);
  endfunction

  function automatic void compare_field(input string field, input logic signed [16:0] expv,
                                        input logic signed [16:0] got);
    if (expv !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        for (int s = 0; s < WINDOW; s++) begin
          window_ring[a][s] = '0;
        end
        window_sum[a] = 0;
        last_sum[a]   = 0;
      end
      next_slot  = 0;
      primed     = 1'b0;
      threshold  = THR_W'(THR_RESET);
      mismatches = 0;
      pending    = 0;
      expected_averages.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        threshold = change_threshold_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_averages.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual avg %0d %0d %0d changed %0b",
                   $time, avg_x_i, avg_y_i, avg_z_i, changed_i);
          mismatches++;
        end else begin
          want = expected_averages.pop_front();
          compare_field("avg_x", want.x, avg_x_i);
          compare_field("avg_y", want.y, avg_y_i);
          compare_field("avg_z", want.z, avg_z_i);
          compare_field("changed", {16'b0, want.changed}, {16'b0, changed_i});
        end
      end
      if (in_valid_i && in_ready_i) begin
        filter_sample(accel_x_i, accel_y_i, accel_z_i);
      end
      pending = expected_averages.size();
    end
  end

endmodule

// File: tb/sv/three_axis_moving_average_change_detect_top_test.sv
// Stimulus and verdict for the three-axis moving average with change detection.
module three_axis_moving_average_change_detect_top_test;
  import tamacd_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  smp_t             accel_x;
  smp_t             accel_y;
  smp_t             accel_z;
  logic             out_valid;
  logic             out_ready;
  smp_t             avg_x;
  smp_t             avg_y;
  smp_t             avg_z;
  logic             changed;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [THR_W-1:0] change_threshold;

  int mismatch_count;
  int pending_averages;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int drift[AXES];

  three_axis_moving_average_change_detect_top uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .accel_x_i          (accel_x),
    .accel_y_i          (accel_y),
    .accel_z_i          (accel_z),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .avg_x_o            (avg_x),
    .avg_y_o            (avg_y),
    .avg_z_o            (avg_z),
    .changed_o          (changed),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .change_threshold_i (change_threshold)
  );

  three_axis_moving_average_change_detect_checker checker_i (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .accel_x_i          (accel_x),
    .accel_y_i          (accel_y),
    .accel_z_i          (accel_z),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .avg_x_i            (avg_x),
    .avg_y_i            (avg_y),
    .avg_z_i            (avg_z),
    .changed_i          (changed),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .change_threshold_i (change_threshold),
    .mismatch_count_o   (mismatch_count),
    .pending_averages_o (pending_averages)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_600_000;
    $display("TEST FAILED");
    $finish;
  end

  // The receiver serves long hold-off requests by counting the stalled cycles itself.
  initial begin
    int stall_left;
    int holds_served;
    stall_left   = 0;
    holds_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall_left   = 60;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_sample(input smp_t sx, input smp_t sy, input smp_t sz);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x  <= sx;
    accel_y  <= sy;
    accel_z  <= sz;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_averages != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    bit taken;
    wait_until_drained();
    cfg_valid        <= 1'b1;
    change_threshold <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_sample();
    smp_t        v[AXES];
    int unsigned kind;
    int          spread;
    kind   = $urandom_range(0, 99);
    spread = (kind < 60) ? 0 : $urandom_range(0, 600);
    for (int a = 0; a < AXES; a++) begin
      if (kind < 25) begin
        v[a] = smp_t'($urandom);
      end else if (kind < 35) begin
        case ($urandom_range(0, 3))
          0: v[a] = 16'sh7FFF;
          1: v[a] = 16'sh8000;
          2: v[a] = 16'sh0000;
          default: v[a] = 16'shFFFF;
        endcase
      end else begin
        drift[a] = drift[a] + int'($urandom_range(0, 2 * spread)) - spread;
        if (drift[a] > 32767) begin
          drift[a] = 32767;
        end else if (drift[a] < -32768) begin
          drift[a] = -32768;
        end
        v[a] = smp_t'(drift[a]);
      end
    end
    send_sample(v[0], v[1], v[2]);
  endtask

  task automatic run_random(input int count, input int pause_at, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        wait_until_drained();
      end
      if (i == hold_at) begin
        hold_requests <= hold_requests + 1;
      end
      send_random_sample();
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    accel_x          <= '0;
    accel_y          <= '0;
    accel_z          <= '0;
    cfg_valid        <= 1'b0;
    change_threshold <= '0;
    for (int a = 0; a < AXES; a++) begin
      drift[a] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct <= 81;

    // Priming, then changes equal to and just past the reset limit on x, equal to it on y and just past it on z.
    send_sample(-5, 0, 0);
    send_sample(2040, 0, 0);
    send_sample(2091, 0, 0);
    send_sample(0, -2090, 0);
    send_sample(0, 0, 2091);
    repeat (8) send_sample(32767, -32768, -1);
    repeat (6) send_sample(-32768, 32767, 1);
    send_sample(0, 0, 0);
    send_sample(-1, -1, -1);
    send_sample(16'sh5555, 16'shAAAA, 16'sh7FFF);

    write_threshold('0);
    run_random(650, 320, -1);

    send_idle_pct = 81;
    recv_idle_pct <= 35;
    write_threshold('1);
    run_random(650, -1, -1);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_threshold(THR_W'($urandom_range(1, 3000)));
    run_random(650, -1, 100);

    wait_until_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_averages == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
